[rtl/grr_pkg.sv]
package grr_pkg;

  localparam int GRR_MAX_GROUP = 16;
  localparam int GRR_VAL_W     = 32;
  localparam int GRR_CFG_W     = 5;
  // wide enough for the largest group the design supports (16)
  localparam int GRR_CNT_W     = 9;
  localparam int GRR_ADDR_W    = 9;

  typedef struct packed {
    logic                 bank;
    logic [GRR_CNT_W-1:0] count;
    logic                 rev;
    logic                 last;
  } grr_cmd_t;

  typedef struct packed {
    logic                  en;
    logic [GRR_ADDR_W-1:0] addr;
    logic [GRR_VAL_W-1:0]  data;
  } grr_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } grr_done_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } grr_state_t;

endpackage

[rtl/grr_front.sv]
module grr_front #(
  parameter int MAX_GROUP = grr_pkg::GRR_MAX_GROUP
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [grr_pkg::GRR_CFG_W-1:0]    group_size,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [grr_pkg::GRR_VAL_W-1:0] item_value,
  input  logic                             final_item,
  input  logic                             q_full,
  output logic                             push,
  output grr_pkg::grr_cmd_t                cmd,
  output grr_pkg::grr_wr_t                 wr,
  input  grr_pkg::grr_done_t               done
);
  import grr_pkg::*;

  localparam int CntW = $clog2(MAX_GROUP + 1);
  localparam int IdxW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic            wr_bank;
  logic [CntW-1:0] fill;
  logic [1:0]      busy, busy_next;
  logic [CntW-1:0] eff_size, idx_c, n;
  logic            accept, full_grp, emit;

  always_comb begin
    if (group_size == '0) begin
      eff_size = CntW'(1);
    end else if (int'(group_size) > MAX_GROUP) begin
      eff_size = CntW'(MAX_GROUP);
    end else begin
      eff_size = CntW'(group_size);
    end
  end

  always_comb begin
    if (int'(fill) >= MAX_GROUP) begin
      idx_c = CntW'(MAX_GROUP - 1);
    end else begin
      idx_c = fill;
    end
  end

  assign n        = idx_c + CntW'(1);
  assign in_ready = !busy[wr_bank] && !q_full;
  assign accept   = in_valid && in_ready;
  assign full_grp = (n >= eff_size);
  assign emit     = full_grp || final_item;

  assign push       = accept && emit;
  assign cmd.bank   = wr_bank;
  assign cmd.count  = GRR_CNT_W'(n);
  assign cmd.rev    = full_grp;
  assign cmd.last   = final_item;

  assign wr.en   = accept;
  assign wr.addr = GRR_ADDR_W'({wr_bank, idx_c[IdxW-1:0]});
  assign wr.data = item_value;

  // a bank stays busy from the group push until the back end has read it out
  always_comb begin
    busy_next = busy;
    if (done.en) begin
      busy_next[done.bank] = 1'b0;
    end
    if (push) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      wr_bank <= 1'b0;
      busy    <= '0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (emit) begin
          fill    <= '0;
          wr_bank <= ~wr_bank;
        end else begin
          fill <= n;
        end
      end
    end
  end

endmodule

[rtl/grr_queue.sv]
module grr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  grr_pkg::grr_cmd_t push_cmd,
  input  logic              pop,
  output grr_pkg::grr_cmd_t head,
  output logic              not_empty,
  output logic              full
);
  import grr_pkg::*;

  grr_cmd_t   ent [2];
  logic       wptr, rptr;
  logic [1:0] cnt;

  assign head      = ent[rptr];
  assign not_empty = (cnt != 2'd0);
  assign full      = (cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

[rtl/grr_back.sv]
module grr_back #(
  parameter int MAX_GROUP = grr_pkg::GRR_MAX_GROUP
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  grr_pkg::grr_wr_t                     wr,
  input  logic                                 q_valid,
  input  grr_pkg::grr_cmd_t                    q_head,
  output logic                                 q_pop,
  output grr_pkg::grr_done_t                   done,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [grr_pkg::GRR_VAL_W-1:0] out_value,
  output logic                                 list_end
);
  import grr_pkg::*;

  localparam int CntW  = $clog2(MAX_GROUP + 1);
  localparam int IdxW  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int AddrW = IdxW + 1;
  localparam int Depth = 2 ** AddrW;

  logic [GRR_VAL_W-1:0] mem [Depth];

  grr_state_t           state, state_next;
  grr_cmd_t             cur;
  logic [CntW-1:0]      k, cnt, idx_c;
  logic [AddrW-1:0]     rd_addr;
  logic                 last_k, adv, can_issue, issue;
  logic                 rd_valid, rd_last;
  logic [GRR_VAL_W-1:0] rd_data;
  logic [GRR_VAL_W-1:0] out_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AddrW-1:0]] <= wr.data;
    end
  end

  assign cnt       = cur.count[CntW-1:0];
  assign last_k    = (k == cnt - CntW'(1));
  assign adv       = !out_valid || out_ready;
  assign can_issue = !rd_valid || adv;
  assign issue     = (state == BK_RUN) && can_issue;
  assign idx_c     = cur.rev ? (cnt - CntW'(1) - k) : k;
  assign rd_addr   = {cur.bank, idx_c[IdxW-1:0]};

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue && last_k && !q_valid) begin
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  // next group is taken straight after the last read of the current one
  always_comb begin
    q_pop     = ((state == BK_IDLE) && q_valid) || (issue && last_k && q_valid);
    done.en   = issue && last_k;
    done.bank = cur.bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        k <= '0;
      end else if (issue) begin
        k <= k + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // registered read, then output register
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_addr];
      rd_last <= cur.last && last_k;
    end
    if (adv && rd_valid) begin
      out_data <= rd_data;
      list_end <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (adv) begin
        rd_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= rd_valid;
      end
    end
  end

  assign out_value = out_data;

endmodule

[rtl/group_reverse_reorder.sv]
// path: a closing beat pushes a command into the queue; the idle back end pops it and issues
//   reads through the read register and the output register; throughput: reads stream
//   one per cycle from the single memory read port while the output is not stalled, and
//   input stalls while the bank to be written waits to be read out or the queue is full
// reset: synchronous, active high; clears fill count, bank flags, queue and output valid,
//   group_size returns to 1
module group_reverse_reorder #(
  parameter int MAX_GROUP = grr_pkg::GRR_MAX_GROUP
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [grr_pkg::GRR_CFG_W-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [grr_pkg::GRR_VAL_W-1:0] item_value,
  input  logic                                 final_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [grr_pkg::GRR_VAL_W-1:0] out_value,
  output logic                                 list_end
);
  import grr_pkg::*;

  logic [GRR_CFG_W-1:0] group_size;
  logic                 push, q_full, q_valid, q_pop;
  grr_cmd_t             cmd, q_head;
  grr_wr_t              wr;
  grr_done_t            done;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GRR_CFG_W'(1);
    end else if (cfg_wen) begin
      group_size <= cfg_wdata;
    end
  end

  grr_front #(.MAX_GROUP(MAX_GROUP)) u_front (
    .clk        (clk),
    .rst        (rst),
    .group_size (group_size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_value (item_value),
    .final_item (final_item),
    .q_full     (q_full),
    .push       (push),
    .cmd        (cmd),
    .wr         (wr),
    .done       (done)
  );

  grr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (cmd),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  grr_back #(.MAX_GROUP(MAX_GROUP)) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .done      (done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .list_end  (list_end)
  );

endmodule

[rtl/grr_checker.sv]
module grr_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [grr_pkg::GRR_VAL_W-1:0] out_value,
  input logic                                 list_end
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(list_end))
    else $error("output beat changed while stalled");

  // nothing leaves right after reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // both banks are free after reset
  a_rst_ready: assert property (@(posedge clk)
    $past(rst) |-> in_ready)
    else $error("input not ready after reset");

  // with nothing in flight on the output, a new beat cannot appear from reset state
  a_no_early_out: assert property (@(posedge clk)
    $past(rst) && $past(rst, 2) |=> !out_valid)
    else $error("output beat without any input");

endmodule

bind group_reverse_reorder grr_checker u_grr_checker (.*);
